### src/cvn_pkg.sv
// Shared constants for the complex vector normalizer: opcodes, result kinds,
// fixed-point constants and the register map of the configuration port.
// No dependencies.
package cvn_pkg;

	// Item opcodes. Code 3 is unused and is dropped without effect.
	localparam logic [1:0] OP_ACCUM  = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_SCALE  = 2'd2;

	localparam logic RESULT_SAMPLE = 1'b0;
	localparam logic RESULT_NORM   = 1'b1;

	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_GRID_STEP = '0;

	localparam logic [31:0] GRID_STEP_RESET = 32'h0100_0000;
	localparam logic [31:0] RECIP_ONE       = 32'h0100_0000;
	localparam logic [31:0] RECIP_MAX       = 32'hFFFF_FFFF;

	// Fraction bits of the reciprocal and bits of the 2^40 / norm quotient.
	localparam int RECIP_FRAC = 24;
	localparam int DIV_BITS   = 41;

endpackage

### src/cvn_ifs.sv
// Handshake channels of the complex vector normalizer: the item channel and
// the result channel, each with source, sink and monitor views.
// Depends on nothing.
interface cvn_cmd_if #(parameter int SAMPLE_WIDTH = 24) ();
	logic                           valid;
	logic                           ready;
	logic [1:0]                     opcode;
	logic signed [SAMPLE_WIDTH-1:0] sample_re;
	logic signed [SAMPLE_WIDTH-1:0] sample_im;

	modport source (output valid, opcode, sample_re, sample_im, input ready);
	modport sink (input valid, opcode, sample_re, sample_im, output ready);
	modport mon (input valid, ready, opcode, sample_re, sample_im);
endinterface

interface cvn_rsp_if #(parameter int SAMPLE_WIDTH = 24) ();
	logic                           valid;
	logic                           ready;
	logic                           result_kind;
	logic signed [SAMPLE_WIDTH-1:0] scaled_re;
	logic signed [SAMPLE_WIDTH-1:0] scaled_im;
	logic [31:0]                    norm_value;
	logic                           zero_norm;
	logic                           saturated;

	modport source (output valid, result_kind, scaled_re, scaled_im, norm_value,
		zero_norm, saturated, input ready);
	modport sink (input valid, result_kind, scaled_re, scaled_im, norm_value,
		zero_norm, saturated, output ready);
	modport mon (input valid, ready, result_kind, scaled_re, scaled_im, norm_value,
		zero_norm, saturated);
endinterface

### src/complex_vector_normalizer_top.sv
// Accumulate item: the multiply steps add both squared magnitudes to the sum; no result.
// Scale item: both parts are scaled into the result register before the next item is taken.
// Finish item: 3 multiply steps, 32 square-root steps and 41 division steps on
// the shared subtractor, then the result register; a zero sum or zero root skips ahead.
// The steps run on the shared 32x32 multiplier and the shared 65-bit subtractor.
// arst_n clears the sum, sets reciprocal and grid_step to 1.0 and drops results.
module complex_vector_normalizer_top
	import cvn_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	cvn_cmd_if.sink            cmd,
	cvn_rsp_if.source          rsp
);

	localparam int NORM_SHIFT = 2 * SAMPLE_WIDTH - 10;
	localparam logic [5:0] DIV_TOP = 6'(DIV_BITS - 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_SQRT = 5'b00100,
		S_DIV  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	typedef logic [SAMPLE_WIDTH-1:0] smp_t;

	// Rounds a magnitude times reciprocal product half away from zero and
	// clips it to the signed sample range. Returns {clipped, value}.
	function automatic logic [SAMPLE_WIDTH:0] round_sat(input logic [63:0] p, input logic neg);
		logic [40:0] r;
		logic [40:0] lim;
		smp_t        v;
		logic        s;
		r   = 41'(p >> RECIP_FRAC) + 41'(p[RECIP_FRAC-1]);
		lim = 41'(1) << (SAMPLE_WIDTH - 1);
		s   = 1'b0;
		if (neg) begin
			if (r > lim) begin
				r = lim;
				s = 1'b1;
			end
			v = SAMPLE_WIDTH'(41'd0 - r);
		end else begin
			if (r > lim - 41'd1) begin
				r = lim - 41'd1;
				s = 1'b1;
			end
			v = SAMPLE_WIDTH'(r);
		end
		return {s, v};
	endfunction

	state_t      state_q;
	logic [1:0]  step_q;
	logic [5:0]  cnt_q;
	logic        out_valid_q;
	logic [31:0] grid_q;
	logic [63:0] sum_q;
	logic [31:0] recip_q;

	logic [1:0]  op_q;
	smp_t        re_mag_q, im_mag_q;
	logic        re_neg_q, im_neg_q;
	logic [63:0] prod_q;
	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [31:0] rem_q;
	logic [40:0] quo_q;
	smp_t        pend_re_q, pend_im_q;
	logic        pend_sat_q, pend_zero_q;

	logic                  rsp_kind_q;
	smp_t                  rsp_re_q, rsp_im_q;
	logic [31:0]           rsp_norm_q;
	logic                  rsp_zero_q, rsp_sat_q;

	logic        cmd_xfer, cfg_write, emit_load, sum_zero;
	smp_t        in_re, in_im;
	logic [31:0] mul_a, mul_b;
	logic [63:0] sub_a, sub_b;
	logic [64:0] diff;
	logic        sub_ge;
	logic [32:0] div_shift;
	logic [63:0] res_nxt;
	logic [40:0] quo_nxt;
	logic [95:0] fin_full;
	logic [127:0] fin_wide;
	logic        fin_clamp;
	logic [63:0] fin_sq;
	logic [64:0] sum_add;
	logic [SAMPLE_WIDTH:0] rnd;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign cfg_write = psel && penable && pwrite && (paddr == ADDR_GRID_STEP);
	assign pready    = 1'b1;
	assign prdata    = (paddr == ADDR_GRID_STEP) ? grid_q : '0;
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);
	assign sum_zero  = (sum_q == '0);

	assign in_re = cmd.sample_re[SAMPLE_WIDTH-1] ? smp_t'(~cmd.sample_re + 1'b1) : cmd.sample_re;
	assign in_im = cmd.sample_im[SAMPLE_WIDTH-1] ? smp_t'(~cmd.sample_im + 1'b1) : cmd.sample_im;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op_q)
			OP_ACCUM: begin
				mul_a = (step_q == 2'd0) ? 32'(re_mag_q) : 32'(im_mag_q);
				mul_b = mul_a;
			end
			OP_SCALE: begin
				mul_a = (step_q == 2'd0) ? 32'(re_mag_q) : 32'(im_mag_q);
				mul_b = recip_q;
			end
			OP_FINISH: begin
				mul_a = (step_q == 2'd0) ? sum_q[31:0] : sum_q[63:32];
				mul_b = grid_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// The subtractor is shared by the square root and the divider.
	assign div_shift = {rem_q, (cnt_q == DIV_TOP)};
	always_comb begin
		if (state_q == S_DIV) begin
			sub_a = 64'(div_shift);
			sub_b = 64'(res_q[31:0]);
		end else begin
			sub_a = x_q;
			sub_b = res_q + bit_q;
		end
	end
	assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge  = !diff[64];
	assign res_nxt = sub_ge ? (res_q >> 1) + bit_q : (res_q >> 1);
	assign quo_nxt = {quo_q[DIV_BITS-2:0], sub_ge};

	// Product of the sum and grid_step, aligned to a squared Q16.16 norm.
	assign fin_full  = (96'(prod_q) << 32) + 96'(x_q);
	assign fin_wide  = 128'(fin_full);
	assign fin_clamp = (fin_wide >> (NORM_SHIFT + 64)) != '0;
	assign fin_sq    = fin_clamp ? '1 : 64'(fin_wide >> NORM_SHIFT);

	assign sum_add = {1'b0, sum_q} + {1'b0, prod_q};
	assign rnd     = round_sat(prod_q, (step_q == 2'd1) ? re_neg_q : im_neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			grid_q      <= GRID_STEP_RESET;
			sum_q       <= '0;
			recip_q     <= RECIP_ONE;
		end else begin
			if (cfg_write) begin
				grid_q <= pwdata;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (cmd_xfer && (cmd.opcode == OP_ACCUM || cmd.opcode == OP_SCALE ||
							cmd.opcode == OP_FINISH)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 2'd1;
					unique case (op_q)
						OP_ACCUM: begin
							if (step_q != 2'd0) begin
								sum_q <= sum_add[64] ? '1 : sum_add[63:0];
							end
							if (step_q == 2'd2) begin
								state_q <= S_IDLE;
							end
						end
						OP_SCALE: begin
							if (step_q == 2'd2) begin
								state_q <= S_EMIT;
							end
						end
						OP_FINISH: begin
							if (step_q == 2'd0 && sum_zero) begin
								recip_q <= RECIP_ONE;
								state_q <= S_EMIT;
							end else if (step_q == 2'd2) begin
								sum_q   <= '0;
								state_q <= S_SQRT;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SQRT: begin
					if (bit_q[0]) begin
						if (res_nxt == '0) begin
							recip_q <= RECIP_MAX;
							state_q <= S_EMIT;
						end else begin
							cnt_q   <= DIV_TOP;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						recip_q <= (quo_nxt[DIV_BITS-1:32] != '0) ? RECIP_MAX : quo_nxt[31:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_q        <= cmd.opcode;
			re_mag_q    <= in_re;
			im_mag_q    <= in_im;
			re_neg_q    <= cmd.sample_re[SAMPLE_WIDTH-1];
			im_neg_q    <= cmd.sample_im[SAMPLE_WIDTH-1];
			pend_sat_q  <= 1'b0;
			pend_zero_q <= 1'b0;
		end
		if (state_q == S_MUL) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
			if (op_q == OP_SCALE && step_q == 2'd1) begin
				pend_re_q  <= rnd[SAMPLE_WIDTH-1:0];
				pend_sat_q <= pend_sat_q | rnd[SAMPLE_WIDTH];
			end
			if (op_q == OP_SCALE && step_q == 2'd2) begin
				pend_im_q  <= rnd[SAMPLE_WIDTH-1:0];
				pend_sat_q <= pend_sat_q | rnd[SAMPLE_WIDTH];
			end
			if (op_q == OP_FINISH && step_q == 2'd0 && sum_zero) begin
				pend_zero_q <= 1'b1;
				res_q       <= '0;
			end
			if (op_q == OP_FINISH && step_q == 2'd1) begin
				x_q <= prod_q;
			end
			if (op_q == OP_FINISH && step_q == 2'd2) begin
				x_q        <= fin_sq;
				pend_sat_q <= pend_sat_q | fin_clamp;
				res_q      <= '0;
				bit_q      <= 64'(1) << 62;
			end
		end
		if (state_q == S_SQRT) begin
			if (sub_ge) begin
				x_q <= diff[63:0];
			end
			res_q <= res_nxt;
			bit_q <= bit_q >> 2;
			rem_q <= '0;
			quo_q <= '0;
			if (bit_q[0] && res_nxt == '0) begin
				pend_sat_q <= 1'b1;
			end
		end
		if (state_q == S_DIV) begin
			rem_q <= sub_ge ? diff[31:0] : div_shift[31:0];
			quo_q <= quo_nxt;
			if (cnt_q == '0 && quo_nxt[DIV_BITS-1:32] != '0) begin
				pend_sat_q <= 1'b1;
			end
		end
		if (emit_load) begin
			rsp_kind_q <= (op_q == OP_FINISH) ? RESULT_NORM : RESULT_SAMPLE;
			rsp_re_q   <= (op_q == OP_FINISH) ? '0 : pend_re_q;
			rsp_im_q   <= (op_q == OP_FINISH) ? '0 : pend_im_q;
			rsp_norm_q <= (op_q == OP_FINISH) ? res_q[31:0] : '0;
			rsp_zero_q <= pend_zero_q;
			rsp_sat_q  <= pend_sat_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.scaled_re   = rsp_re_q;
	assign rsp.scaled_im   = rsp_im_q;
	assign rsp.norm_value  = rsp_norm_q;
	assign rsp.zero_norm   = rsp_zero_q;
	assign rsp.saturated   = rsp_sat_q;

endmodule

### src/cvn_checker.sv
// Port-level checks for the complex vector normalizer and the bind that
// attaches them to complex_vector_normalizer_top. Depends on cvn_pkg.
module cvn_checker
	import cvn_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 24
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_ready,
	input logic [1:0]                     cmd_opcode,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           result_kind,
	input logic signed [SAMPLE_WIDTH-1:0] scaled_re,
	input logic signed [SAMPLE_WIDTH-1:0] scaled_im,
	input logic [31:0]                    norm_value,
	input logic                           zero_norm,
	input logic                           saturated
);

	// A stalled result stays in place until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(norm_value) &&
		$stable(scaled_re) && $stable(scaled_im) && $stable(result_kind))
		else $error("result changed while stalled");

	// Every valid item takes the sequencer out of idle and drops ready after the
	// transfer. The unused opcode is dropped in the transfer cycle and leaves the channel ready.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_opcode == OP_ACCUM || cmd_opcode == OP_FINISH ||
		cmd_opcode == OP_SCALE) |=> !cmd_ready)
		else $error("item channel ready right after a transfer");

	a_norm_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_kind == RESULT_NORM |-> scaled_re == '0 && scaled_im == '0)
		else $error("norm report carries sample data");

	a_sample_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_kind == RESULT_SAMPLE |-> norm_value == '0 && !zero_norm)
		else $error("sample result carries norm data");

	// A zero sum reports an unclipped zero norm and resets the reciprocal to unity.
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && zero_norm |-> result_kind == RESULT_NORM && norm_value == '0 &&
		!saturated)
		else $error("inconsistent zero-norm report");

endmodule

bind complex_vector_normalizer_top cvn_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cvn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_opcode  (cmd.opcode),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.result_kind (rsp.result_kind),
	.scaled_re   (rsp.scaled_re),
	.scaled_im   (rsp.scaled_im),
	.norm_value  (rsp.norm_value),
	.zero_norm   (rsp.zero_norm),
	.saturated   (rsp.saturated)
);

### tb/tb_complex_vector_normalizer_top.sv
// Self-checking testbench for complex_vector_normalizer_top: streams accumulate, finish and
// scale items and checks every result against a fixed-point model of the normalizer.
// Depends on cvn_pkg, cvn_cmd_if / cvn_rsp_if and complex_vector_normalizer_top.
module tb_complex_vector_normalizer_top;
	import cvn_pkg::*;

	localparam int SW = 24;
	localparam int NORM_SHIFT = 2 * SW - 10;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] S_ONE = 1;
	localparam logic signed [SW-1:0] S_NEG_ONE = -1;
	localparam logic [32:0] HALF_RANGE = 33'd1 << (SW - 1);
	localparam int IDLE_WAIT = 100;
	localparam int LONG_HOLD = 400;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic          kind;
		logic [SW-1:0] re;
		logic [SW-1:0] im;
		logic [31:0]   norm;
		logic          zero;
		logic          sat;
	} norm_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	cvn_cmd_if #(.SAMPLE_WIDTH(SW)) cmd_ch ();
	cvn_rsp_if #(.SAMPLE_WIDTH(SW)) rsp_ch ();

	complex_vector_normalizer_top #(.SAMPLE_WIDTH(SW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// Model state of the normalizer.
	logic [31:0] grid_step_q;
	logic [63:0] acc_sum;
	logic [31:0] recip_q;

	norm_result_t norm_scale_queue[$];

	int  mismatches;
	int  sent_items;
	int  results_checked;
	int  norm_reports;
	int  zero_reports;
	int  clipped_results;
	int  long_stalls;
	int  grid_settings;
	bit  quiet;
	bit  hold_output;
	int  cycle_count;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [SW-1:0] magnitude(logic signed [SW-1:0] v);
		return v[SW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [31:0] floor_root(logic [63:0] x);
		logic [31:0] root;
		logic [63:0] trial;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = 64'(root | (32'd1 << i));
			if (trial * trial <= x)
				root = root | (32'd1 << i);
		end
		return root;
	endfunction

	// Product with the reciprocal, rounded half away from zero, clipped to the sample range.
	function automatic logic [SW-1:0] scale_part(logic signed [SW-1:0] v, inout bit clip);
		logic [SW+31:0] p;
		logic [32:0]    r;
		p = (SW+32)'(magnitude(v)) * (SW+32)'(recip_q);
		r = 33'(p >> RECIP_FRAC) + 33'(p[RECIP_FRAC-1]);
		if (v[SW-1]) begin
			if (r > HALF_RANGE) begin
				r = HALF_RANGE;
				clip = 1'b1;
			end
			return ~r[SW-1:0] + 1'b1;
		end
		if (r > HALF_RANGE - 1) begin
			r = HALF_RANGE - 1;
			clip = 1'b1;
		end
		return r[SW-1:0];
	endfunction

	task automatic normalize_item(logic [1:0] op, logic signed [SW-1:0] re,
		logic signed [SW-1:0] im);
		norm_result_t r;
		logic [SW-1:0] ma;
		logic [SW-1:0] mb;
		logic [2*SW:0] energy;
		logic [64:0]   wide_sum;
		logic [95:0]   prod;
		logic [63:0]   sq;
		logic [31:0]   root;
		logic [63:0]   quot;
		bit            clip;
		r = '0;
		clip = 1'b0;
		case (op)
			OP_ACCUM: begin
				ma = magnitude(re);
				mb = magnitude(im);
				energy = (2*SW+1)'(ma) * (2*SW+1)'(ma) + (2*SW+1)'(mb) * (2*SW+1)'(mb);
				wide_sum = {1'b0, acc_sum} + 65'(energy);
				acc_sum = wide_sum[64] ? '1 : wide_sum[63:0];
			end
			OP_FINISH: begin
				r.kind = RESULT_NORM;
				if (acc_sum == '0) begin
					r.zero = 1'b1;
					recip_q = RECIP_ONE;
				end else begin
					prod = 96'(acc_sum) * 96'(grid_step_q);
					if ((prod >> (64 + NORM_SHIFT)) != '0) begin
						sq = '1;
						clip = 1'b1;
					end else begin
						sq = 64'(prod >> NORM_SHIFT);
					end
					root = floor_root(sq);
					r.norm = root;
					if (root == '0) begin
						recip_q = RECIP_MAX;
						clip = 1'b1;
					end else begin
						quot = (64'd1 << (DIV_BITS - 1)) / 64'(root);
						if (quot > 64'(RECIP_MAX)) begin
							quot = 64'(RECIP_MAX);
							clip = 1'b1;
						end
						recip_q = quot[31:0];
					end
				end
				acc_sum = '0;
				r.sat = clip;
				norm_scale_queue.push_back(r);
			end
			OP_SCALE: begin
				r.kind = RESULT_SAMPLE;
				r.re = scale_part(re, clip);
				r.im = scale_part(im, clip);
				r.sat = clip;
				norm_scale_queue.push_back(r);
			end
			default: ;
		endcase
	endtask

	function automatic int pick_shift();
		case ($urandom_range(0, 7))
			4: return $urandom_range(1, 8);
			5: return $urandom_range(9, 16);
			6: return $urandom_range(17, SW - 2);
			7: return SW - 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic signed [SW-1:0] rand_sample(int shift);
		logic signed [SW-1:0] s;
		case ($urandom_range(0, 15))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			default: begin
				s = SW'($urandom());
				return s >>> shift;
			end
		endcase
	endfunction

	// Offers one item and returns at the rising edge where it transfers.
	task automatic send_item(logic [1:0] op, logic signed [SW-1:0] re, logic signed [SW-1:0] im);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.opcode = op;
		cmd_ch.sample_re = re;
		cmd_ch.sample_im = im;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		normalize_item(op, re, im);
		if (op != OP_UNUSED)
			sent_items++;
	endtask

	// The block is idle once every result is in and a finish has had time to complete.
	task automatic wait_idle();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (norm_scale_queue.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic program_grid_step(logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_GRID_STEP;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		grid_step_q = value;
		grid_settings++;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== value) begin
			$error("grid_step readback mismatch: expected %0h, actual %0h", value, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Vectors: an accumulate pass, a finish and a scale pass, with the odd broken sequence
	// (missing finish, doubled finish, short scale pass) and stray unused opcodes.
	task automatic run_vector_stream(int budget);
		int start;
		int len;
		int n_scale;
		int acc_shift;
		int scl_shift;
		int shape;
		start = sent_items;
		while (sent_items - start < budget) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
			acc_shift = pick_shift();
			scl_shift = pick_shift();
			shape = $urandom_range(0, 11);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_item(OP_UNUSED, rand_sample(0), rand_sample(0));
				send_item(OP_ACCUM, rand_sample(acc_shift), rand_sample(acc_shift));
			end
			if (shape != 0)
				send_item(OP_FINISH, rand_sample(0), rand_sample(0));
			if (shape == 1)
				send_item(OP_FINISH, rand_sample(0), rand_sample(0));
			n_scale = (shape == 2) ? $urandom_range(0, 3) : len;
			for (int i = 0; i < n_scale; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_item(OP_SCALE, rand_sample(pick_shift()), rand_sample(pick_shift()));
				else
					send_item(OP_SCALE, rand_sample(scl_shift), rand_sample(scl_shift));
			end
		end
	endtask

	task automatic test_directed_cases();
		// Finish on an empty sum reports a zero norm and keeps the unity reciprocal.
		send_item(OP_FINISH, S_MAX, S_MIN);
		send_item(OP_SCALE, S_MAX, S_MIN);
		send_item(OP_SCALE, '0, '0);
		send_item(OP_SCALE, S_ONE, S_NEG_ONE);
		send_item(OP_UNUSED, S_MAX, S_MIN);
		send_item(OP_ACCUM, S_MIN, S_MIN);
		send_item(OP_ACCUM, S_MAX, S_MAX);
		send_item(OP_FINISH, '0, '0);
		send_item(OP_SCALE, S_MAX, S_MIN);
		send_item(OP_SCALE, S_NEG_ONE, S_ONE);
		// A single LSB squared vanishes in the root, so the reciprocal clips high.
		send_item(OP_ACCUM, S_ONE, '0);
		send_item(OP_FINISH, S_MIN, S_MAX);
		send_item(OP_SCALE, S_MAX, S_MIN);
		send_item(OP_SCALE, S_ONE, S_NEG_ONE);
		send_item(OP_SCALE, '0, '0);
		// A norm of one LSB overflows the reciprocal.
		send_item(OP_ACCUM, 128, '0);
		send_item(OP_FINISH, '0, '0);
		send_item(OP_SCALE, -5, 7);
		send_item(OP_ACCUM, S_NEG_ONE, '0);
		send_item(OP_UNUSED, S_MIN, S_MAX);
		send_item(OP_FINISH, '0, '0);
		send_item(OP_SCALE, S_MIN, S_MAX);
		send_item(OP_ACCUM, S_MIN, '0);
		send_item(OP_FINISH, '0, '0);
		send_item(OP_SCALE, S_MAX, -S_MAX);
	endtask

	task automatic test_grid_step_sweep();
		logic [31:0] steps[4];
		steps = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_4000};
		foreach (steps[i]) begin
			wait_idle();
			program_grid_step(steps[i]);
			run_vector_stream(100);
		end
		repeat (7) begin
			wait_idle();
			program_grid_step($urandom() >> $urandom_range(0, 31));
			run_vector_stream(150);
		end
	endtask

	// The receiver stops for a long stretch while scale items keep coming in.
	task automatic test_output_stall();
		wait_idle();
		hold_output = 1'b1;
		for (int i = 0; i < 48; i++)
			send_item(OP_SCALE, rand_sample(pick_shift()), rand_sample(pick_shift()));
	endtask

	task automatic test_unbroken_stream();
		wait_idle();
		program_grid_step(GRID_STEP_RESET);
		quiet = 1'b1;
		run_vector_stream(400);
	endtask

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		norm_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (norm_scale_queue.size() == 0) begin
				$error("result transfer with nothing expected: kind %0d", rsp_ch.result_kind);
				mismatches++;
			end else begin
				want = norm_scale_queue.pop_front();
				results_checked++;
				if (want.kind == RESULT_NORM)
					norm_reports++;
				if (want.zero)
					zero_reports++;
				if (want.sat)
					clipped_results++;
				compare_field("result_kind", 32'(want.kind), 32'(rsp_ch.result_kind));
				compare_field("scaled_re", 32'(want.re), 32'($unsigned(rsp_ch.scaled_re)));
				compare_field("scaled_im", 32'(want.im), 32'($unsigned(rsp_ch.scaled_im)));
				compare_field("norm_value", want.norm, rsp_ch.norm_value);
				compare_field("zero_norm", 32'(want.zero), 32'(rsp_ch.zero_norm));
				compare_field("saturated", 32'(want.sat), 32'(rsp_ch.saturated));
			end
		end
	end

	initial begin
		int held;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				rsp_ch.ready = 1'b0;
				held = 0;
				while (held < LONG_HOLD) begin
					@(negedge clk);
					held++;
				end
				hold_output = 1'b0;
				long_stalls++;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
			norm_scale_queue.size());
		$display("tb_complex_vector_normalizer_top NOT OK");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_GRID_STEP;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_ACCUM;
		cmd_ch.sample_re = '0;
		cmd_ch.sample_im = '0;
		quiet = 1'b0;
		hold_output = 1'b0;
		mismatches = 0;
		sent_items = 0;
		results_checked = 0;
		norm_reports = 0;
		zero_reports = 0;
		clipped_results = 0;
		long_stalls = 0;
		grid_settings = 0;
		grid_step_q = GRID_STEP_RESET;
		acc_sum = '0;
		recip_q = RECIP_ONE;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_grid_step_sweep();
		test_output_stall();
		test_unbroken_stream();
		wait_idle();

		$display("Sent %0d items under %0d grid_step settings; checked %0d results.",
			sent_items, grid_settings + 1, results_checked);
		$display("Norm reports %0d (zero sum %0d), clipped results %0d, long output stalls %0d.",
			norm_reports, zero_reports, clipped_results, long_stalls);
		if (mismatches == 0)
			$display("tb_complex_vector_normalizer_top OK");
		else
			$display("tb_complex_vector_normalizer_top NOT OK");
		$finish;
	end

endmodule

### sim.f
src/cvn_pkg.sv
src/cvn_ifs.sv
src/complex_vector_normalizer_top.sv
src/cvn_checker.sv
tb/tb_complex_vector_normalizer_top.sv
